FILE: hw/rtl/rc4_pkg.sv
// shared types and constants of the rc4 stream cipher
`timescale 1ns / 1ps
`default_nettype none

package rc4_pkg;

   // longest key kept in the key store, 1 to 256
   localparam int MAX_KEY_BYTES = 256;

   typedef logic [7:0] byte_type;
   typedef logic [8:0] key_cnt_type;

   localparam key_cnt_type KEY_LIMIT = key_cnt_type'(MAX_KEY_BYTES);

   // what a request asks of the engine
   typedef enum logic [1:0] {
      OP_KEY      = 2'd0,
      OP_KEY_LAST = 2'd1,
      OP_DATA     = 2'd2
   } op_type;

   typedef struct packed {
      op_type   op;
      byte_type value;
   } cmd_type;

   typedef struct packed {
      logic       sched_busy;
      logic [1:0] res_cnt;
   } eng_status_type;

endpackage

`default_nettype wire

FILE: hw/rtl/rc4_front.sv
// request stage: takes requests and turns them into engine commands
`timescale 1ns / 1ps
`default_nettype none

module rc4_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic             req_action,
   input  wire logic [7:0]       req_value,
   input  wire logic             req_key_last,
   output logic                  cmd_valid,
   output rc4_pkg::cmd_type      cmd,
   input  wire logic             cmd_ready
);

   logic             valid_ff;
   logic             valid_in;
   rc4_pkg::cmd_type cmd_ff;
   rc4_pkg::cmd_type cmd_in;
   logic             take;

   assign req_ready = !valid_ff || cmd_ready;
   assign take      = req_valid && req_ready;

   always_comb begin
      cmd_in.value = req_value;
      if (req_action) begin
         cmd_in.op = rc4_pkg::OP_DATA;
      end else if (req_key_last) begin
         cmd_in.op = rc4_pkg::OP_KEY_LAST;
      end else begin
         cmd_in.op = rc4_pkg::OP_KEY;
      end
      valid_in = take || (valid_ff && !cmd_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cmd_ff <= cmd_in;
      end
   end

   assign cmd_valid = valid_ff;
   assign cmd       = cmd_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/rc4_cmd_queue.sv
// two-entry command queue between the request stage and the engine
`timescale 1ns / 1ps
`default_nettype none

module rc4_cmd_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire rc4_pkg::cmd_type in_cmd,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output rc4_pkg::cmd_type      out_cmd
);

   rc4_pkg::cmd_type mem_ff [2];
   logic             wr_ff;
   logic             rd_ff;
   logic [1:0]       cnt_ff;
   logic             push;
   logic             pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_cmd   = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) begin
            wr_ff <= !wr_ff;
         end
         if (pop) begin
            rd_ff <= !rd_ff;
         end
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= in_cmd;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/rc4_engine.sv
// cipher engine: key store, state box, key schedule and keystream
`timescale 1ns / 1ps
`default_nettype none

module rc4_engine (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                cmd_valid,
   output logic                     cmd_ready,
   input  wire rc4_pkg::cmd_type    cmd,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [7:0]               rsp_data_out,
   output rc4_pkg::eng_status_type  status
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_READ_I = 2'd1;
   localparam logic [1:0] ST_READ_J = 2'd2;
   localparam logic [1:0] ST_SWAP   = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic                  sched_ff, sched_in;
   logic [7:0]            i_ff, i_in;
   logic [7:0]            j_ff, j_in;
   logic [7:0]            cur_ff, cur_in;
   logic [7:0]            si_ff, si_in;
   logic [7:0]            val_ff, val_in;
   logic [7:0]            k_ff, k_in;
   rc4_pkg::key_cnt_type  klen_ff, klen_in;
   rc4_pkg::key_cnt_type  key_cnt_ff, key_cnt_in;
   logic                  dw_valid_ff, dw_valid_in;
   logic [7:0]            dw_addr_ff, dw_addr_in;
   logic [7:0]            dw_data_ff, dw_data_in;
   logic                  fin_valid_ff, fin_valid_in;
   logic                  fin_match_ff, fin_match_in;
   logic [1:0]            res_cnt_ff;

   // state box memory with per-entry valid bits
   logic [7:0]            sbox_mem [256];
   logic [255:0]          sbox_vld_ff;
   logic [7:0]            sbox_rd_ff;
   logic [7:0]            sbox_rd_addr_ff;
   logic                  sbox_rd_vld_ff;
   logic                  byp_ff;
   logic [7:0]            byp_data_ff;
   logic [7:0]            rd_addr;
   logic                  we;
   logic [7:0]            waddr;
   logic [7:0]            wdata;
   logic                  sbox_clear;
   logic [7:0]            s_val;

   // key store
   logic [7:0]            key_mem [256];
   logic [7:0]            key_rd_ff;
   logic                  key_we;

   // result queue
   logic [7:0]            out_mem_ff [2];
   logic                  out_wr_ff;
   logic                  out_rd_ff;
   logic [1:0]            out_cnt_ff;
   logic                  out_push;
   logic                  rsp_fire;
   logic [7:0]            out_word;

   logic                  pop;
   logic                  data_start;
   rc4_pkg::key_cnt_type  cnt_after;
   logic [8:0]            k_next;
   logic [7:0]            jn;
   logic [7:0]            t_addr;

   assign s_val = byp_ff ? byp_data_ff : (sbox_rd_vld_ff ? sbox_rd_ff : sbox_rd_addr_ff);

   always_comb begin
      pop = 1'b0;
      if (state_ff == ST_IDLE && cmd_valid) begin
         if (cmd.op == rc4_pkg::OP_DATA) begin
            pop = (res_cnt_ff != 2'd2);
         end else begin
            pop = !dw_valid_ff;
         end
      end
   end

   assign cmd_ready  = pop;
   assign data_start = pop && (cmd.op == rc4_pkg::OP_DATA);
   assign cnt_after  = (key_cnt_ff < rc4_pkg::KEY_LIMIT) ? key_cnt_ff + 9'd1 : key_cnt_ff;
   assign k_next     = {1'b0, k_ff} + 9'd1;

   always_comb begin
      state_in     = state_ff;
      sched_in     = sched_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      cur_in       = cur_ff;
      si_in        = si_ff;
      val_in       = val_ff;
      k_in         = k_ff;
      klen_in      = klen_ff;
      key_cnt_in   = key_cnt_ff;
      dw_valid_in  = 1'b0;
      dw_addr_in   = dw_addr_ff;
      dw_data_in   = dw_data_ff;
      fin_valid_in = 1'b0;
      fin_match_in = fin_match_ff;
      rd_addr      = 8'd0;
      we           = dw_valid_ff;
      waddr        = dw_addr_ff;
      wdata        = dw_data_ff;
      sbox_clear   = 1'b0;
      key_we       = 1'b0;
      jn           = j_ff + s_val;
      t_addr       = si_ff + s_val;
      case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               case (cmd.op)
                  rc4_pkg::OP_DATA: begin
                     rd_addr  = i_ff + 8'd1;
                     i_in     = i_ff + 8'd1;
                     cur_in   = i_ff + 8'd1;
                     val_in   = cmd.value;
                     state_in = ST_READ_J;
                  end
                  rc4_pkg::OP_KEY, rc4_pkg::OP_KEY_LAST: begin
                     key_we     = (key_cnt_ff < rc4_pkg::KEY_LIMIT);
                     key_cnt_in = cnt_after;
                     if (cmd.op == rc4_pkg::OP_KEY_LAST) begin
                        klen_in    = cnt_after;
                        key_cnt_in = '0;
                        sbox_clear = 1'b1;
                        i_in       = 8'd0;
                        j_in       = 8'd0;
                        k_in       = 8'd0;
                        sched_in   = 1'b1;
                        state_in   = ST_READ_I;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ_I: begin
            rd_addr  = i_ff;
            cur_in   = i_ff;
            i_in     = i_ff + 8'd1;
            k_in     = (k_next >= klen_ff) ? 8'd0 : k_next[7:0];
            state_in = ST_READ_J;
         end
         ST_READ_J: begin
            if (sched_ff) begin
               jn = j_ff + s_val + key_rd_ff;
            end
            rd_addr  = jn;
            j_in     = jn;
            si_in    = s_val;
            state_in = ST_SWAP;
         end
         ST_SWAP: begin
            we          = 1'b1;
            waddr       = cur_ff;
            wdata       = s_val;
            dw_valid_in = 1'b1;
            dw_addr_in  = j_ff;
            dw_data_in  = si_ff;
            if (!sched_ff) begin
               rd_addr      = t_addr;
               fin_valid_in = 1'b1;
               fin_match_in = (t_addr == j_ff);
               state_in     = ST_IDLE;
            end else if (cur_ff == 8'hFF) begin
               sched_in = 1'b0;
               j_in     = 8'd0;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_READ_I;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sched_ff     <= 1'b0;
         i_ff         <= 8'd0;
         j_ff         <= 8'd0;
         key_cnt_ff   <= '0;
         dw_valid_ff  <= 1'b0;
         fin_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sched_ff     <= sched_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         key_cnt_ff   <= key_cnt_in;
         dw_valid_ff  <= dw_valid_in;
         fin_valid_ff <= fin_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      si_ff        <= si_in;
      val_ff       <= val_in;
      k_ff         <= k_in;
      klen_ff      <= klen_in;
      dw_addr_ff   <= dw_addr_in;
      dw_data_ff   <= dw_data_in;
      fin_match_ff <= fin_match_in;
   end

   // state box: write-first through the bypass, unwritten entries read as identity
   always_ff @(posedge clock) begin
      if (we) begin
         sbox_mem[waddr] <= wdata;
      end
      sbox_rd_ff      <= sbox_mem[rd_addr];
      sbox_rd_addr_ff <= rd_addr;
      sbox_rd_vld_ff  <= sbox_vld_ff[rd_addr];
      byp_ff          <= we && (waddr == rd_addr);
      byp_data_ff     <= wdata;
   end

   always_ff @(posedge clock) begin
      if (reset || sbox_clear) begin
         sbox_vld_ff <= '0;
      end else if (we) begin
         sbox_vld_ff[waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[key_cnt_ff[7:0]] <= cmd.value;
      end
      key_rd_ff <= key_mem[k_ff];
   end

   // results: two slots, reserved when a data request starts
   assign out_push     = fin_valid_ff;
   assign out_word     = val_ff ^ (fin_match_ff ? si_ff : s_val);
   assign rsp_valid    = (out_cnt_ff != 2'd0);
   assign rsp_fire     = rsp_valid && rsp_ready;
   assign rsp_data_out = out_mem_ff[out_rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_wr_ff  <= 1'b0;
         out_rd_ff  <= 1'b0;
         out_cnt_ff <= 2'd0;
         res_cnt_ff <= 2'd0;
      end else begin
         if (out_push) begin
            out_wr_ff <= !out_wr_ff;
         end
         if (rsp_fire) begin
            out_rd_ff <= !out_rd_ff;
         end
         out_cnt_ff <= out_cnt_ff + {1'b0, out_push} - {1'b0, rsp_fire};
         res_cnt_ff <= res_cnt_ff + {1'b0, data_start} - {1'b0, rsp_fire};
      end
   end

   always_ff @(posedge clock) begin
      if (out_push) begin
         out_mem_ff[out_wr_ff] <= out_word;
      end
   end

   assign status.sched_busy = sched_ff;
   assign status.res_cnt    = res_cnt_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/rc4_stream_cipher.sv
// top level of the rc4 stream cipher
`timescale 1ns / 1ps
`default_nettype none

// RC4 engine with a valid/ready request channel and a valid/ready result
// channel. A request with req_action low is a key byte; key bytes are kept
// in order (up to 256, more are dropped) and the one with req_key_last high
// starts the key schedule, which rebuilds the state box from the identity
// and clears both indices. A request with req_action high is a data byte;
// it yields one result, the byte XOR the next keystream byte, so the same
// stream encrypts and decrypts. Key bytes give no result. A data byte is
// worked in steps set by the single read port of the state box memory:
// read S[i], read S[j], then swap and read S[S[i]+S[j]]; the last swap
// write overlaps the next request. A key byte waits while a swap write is
// still pending, as after a data byte. Each of the 256 steps of the key
// schedule reads S[i], reads S[j] and swaps, through the same port. A
// request stage and a two-deep queue sit in front of the engine, so
// requests keep flowing while it works, and two result slots let a result
// wait for rsp_ready without stopping the engine. Data sent before any key
// runs on the reset state (identity box, indices zero).

module rc4_stream_cipher (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_action,
   input  wire logic [7:0]  req_value,
   input  wire logic        req_key_last,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_data_out
);

   // request stage to queue
   logic                    front_valid;
   logic                    front_ready;
   rc4_pkg::cmd_type        front_cmd;

   // queue to engine
   logic                    eng_valid;
   logic                    eng_ready;
   rc4_pkg::cmd_type        eng_cmd;

   rc4_pkg::eng_status_type eng_status;

   // classify each request as key byte, last key byte or data byte
   rc4_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_action   (req_action),
      .req_value    (req_value),
      .req_key_last (req_key_last),
      .cmd_valid    (front_valid),
      .cmd          (front_cmd),
      .cmd_ready    (front_ready)
   );

   // decouples request intake from the engine
   rc4_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_cmd    (front_cmd),
      .out_valid (eng_valid),
      .out_ready (eng_ready),
      .out_cmd   (eng_cmd)
   );

   // key store, key schedule and keystream generation
   rc4_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .cmd_valid    (eng_valid),
      .cmd_ready    (eng_ready),
      .cmd          (eng_cmd),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data_out (rsp_data_out),
      .status       (eng_status)
   );

   // never more results promised than the two result slots hold
   assert property (@(posedge clock) disable iff (reset)
      eng_status.res_cnt != 2'd3)
      else $error("result reservations overflow");

   // a shown result was reserved when its request started
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> eng_status.res_cnt != 2'd0)
      else $error("result without reservation");

   // no data request starts while the key schedule runs
   assert property (@(posedge clock) disable iff (reset)
      (eng_status.sched_busy && $past(eng_status.sched_busy))
         |-> eng_status.res_cnt <= $past(eng_status.res_cnt))
      else $error("data started during key schedule");

   // reset empties the result side
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result present after reset");

endmodule

`default_nettype wire
